>>> hw/rtl/gap_buffer_line_editor_defines.svh
// ----------------------------------------------------------------------------
// Gap buffer line editor: assertion macros
// Shared property forms for the checker of the line editor.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_LINE_EDITOR_DEFINES_SVH
`define GAP_BUFFER_LINE_EDITOR_DEFINES_SVH

// same-cycle implication, off during reset
`define GBL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbl assertion failed");

// next-cycle implication, off during reset
`define GBL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbl assertion failed");

// next-cycle implication, always on
`define GBL_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gbl assertion failed");

`endif

>>> hw/rtl/gbl_pkg.sv
// ----------------------------------------------------------------------------
// Gap buffer line editor package
// Field widths, operation and status codes, and the per-request control word.
// ----------------------------------------------------------------------------
`default_nettype none

package gbl_pkg;

  localparam int GBL_DEPTH = 1024;
  localparam int OP_W      = 3;
  localparam int CH_W      = 8;
  localparam int POS_W     = 10;
  localparam int CNT_OUT_W = 11;
  localparam int ST_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_LEFT   = 3'd1,
    OP_RIGHT  = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE     = 2'd0,
    ST_BOUNDARY = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    logic                 wr_en;
    logic                 wr_from_mem;
    logic                 rd_to_out;
    status_t              status;
    logic [CNT_OUT_W-1:0] text_length;
    logic [CNT_OUT_W-1:0] cursor_pos;
    logic [CH_W-1:0]      ch;
  } gbl_step_t;

endpackage

`default_nettype wire

>>> hw/rtl/gbl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
`default_nettype none

module gbl_ram import gbl_pkg::*; #(
  parameter int WIDTH = CH_W,
  parameter int DEPTH = GBL_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gbl_cursor.sv
// ----------------------------------------------------------------------------
// Gap buffer cursor control
// Holds the left and right counts, decodes a request and produces the store
// read and write addresses and the control word for the result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gbl_cursor import gbl_pkg::*; #(
  parameter int DEPTH = GBL_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step_en,
  input  logic [OP_W-1:0]          op,
  input  logic [CH_W-1:0]          ch_in,
  input  logic [POS_W-1:0]         position,
  output logic                     rd_en,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output gbl_step_t                step
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0] left_cnt;
  logic [CW-1:0] right_cnt;
  logic [CW-1:0] left_cnt_next;
  logic [CW-1:0] right_cnt_next;
  logic [CW-1:0] total;
  logic [CW-1:0] total_next;
  logic [CW-1:0] depth_c;
  logic [PW-1:0] pos_w;
  logic [PW-1:0] left_w;
  logic [PW-1:0] total_w;
  logic [PW-1:0] right_w;
  logic [PW-1:0] depth_w;

  assign total      = left_cnt + right_cnt;
  assign total_next = left_cnt_next + right_cnt_next;
  assign depth_c    = CW'(DEPTH);
  assign pos_w      = PW'(position);
  assign left_w     = PW'(left_cnt);
  assign right_w    = PW'(right_cnt);
  assign total_w    = PW'(total);
  assign depth_w    = PW'(DEPTH);

  always_comb begin
    left_cnt_next    = left_cnt;
    right_cnt_next   = right_cnt;
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_addr          = '0;
    step.wr_en       = 1'b0;
    step.wr_from_mem = 1'b0;
    step.rd_to_out   = 1'b0;
    step.status      = ST_DONE;
    step.ch          = ch_in;
    unique case (op_t'(op))
      OP_INSERT: begin
        if (total >= depth_c) begin
          step.status = ST_FULL;
        end else begin
          step.wr_en    = 1'b1;
          wr_addr       = AW'(left_cnt);
          left_cnt_next = left_cnt + 1'b1;
        end
      end
      OP_LEFT: begin
        if (left_cnt == '0) begin
          step.status = ST_BOUNDARY;
        end else begin
          rd_en            = 1'b1;
          rd_addr          = AW'(left_cnt - 1'b1);
          wr_addr          = AW'(depth_c - right_cnt - 1'b1);
          step.wr_en       = 1'b1;
          step.wr_from_mem = 1'b1;
          left_cnt_next    = left_cnt - 1'b1;
          right_cnt_next   = right_cnt + 1'b1;
        end
      end
      OP_RIGHT: begin
        if (right_cnt == '0) begin
          step.status = ST_BOUNDARY;
        end else begin
          rd_en            = 1'b1;
          rd_addr          = AW'(depth_c - right_cnt);
          wr_addr          = AW'(left_cnt);
          step.wr_en       = 1'b1;
          step.wr_from_mem = 1'b1;
          left_cnt_next    = left_cnt + 1'b1;
          right_cnt_next   = right_cnt - 1'b1;
        end
      end
      OP_DELETE: begin
        if (left_cnt == '0) begin
          step.status = ST_BOUNDARY;
        end else begin
          left_cnt_next = left_cnt - 1'b1;
        end
      end
      OP_READ: begin
        if (pos_w >= total_w) begin
          step.status = ST_RANGE;
        end else begin
          rd_en          = 1'b1;
          step.rd_to_out = 1'b1;
          if (pos_w < left_w) begin
            rd_addr = AW'(pos_w);
          end else begin
            rd_addr = AW'(depth_w - right_w + pos_w - left_w);
          end
        end
      end
      default: begin
        step.status = ST_BOUNDARY;
      end
    endcase
    step.text_length = CNT_OUT_W'(total_next);
    step.cursor_pos  = CNT_OUT_W'(left_cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cnt  <= '0;
      right_cnt <= '0;
    end else if (step_en) begin
      left_cnt  <= left_cnt_next;
      right_cnt <= right_cnt_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gap_buffer_line_editor.sv
// ----------------------------------------------------------------------------
// Gap buffer line editor
// Line of text with a cursor kept as a gap buffer in one store: insert,
// cursor left/right, delete before cursor and positional read.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the result side is not stalled, and
// its result goes through the request, second-stage and result registers. A
// stalled result holds the whole pipeline and the request input with it. The
// store has one read port and one write port: a request reads the store in its
// first stage and writes it in the second, and a read that hits the address
// being written in the same cycle is forwarded. The store is not cleared at
// reset; only entries already written are ever read.
`default_nettype none

module gap_buffer_line_editor import gbl_pkg::*; #(
  parameter int DEPTH = GBL_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  logic [OP_W-1:0]      op,
  input  logic [CH_W-1:0]      ch_in,
  input  logic [POS_W-1:0]     position,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [CH_W-1:0]      ch_out,
  output logic [CNT_OUT_W-1:0] text_length,
  output logic [CNT_OUT_W-1:0] cursor_pos,
  output logic [ST_W-1:0]      status
);

  localparam int AW = $clog2(DEPTH);

  logic            advance;
  logic            step_en;

  logic            s1_valid;
  logic [OP_W-1:0] s1_op;
  logic [CH_W-1:0] s1_ch;
  logic [POS_W-1:0] s1_pos;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  gbl_step_t       step;

  logic            s2_valid;
  gbl_step_t       s2_step;
  logic [AW-1:0]   s2_wr_addr;
  logic            s2_byp_hit;
  logic [CH_W-1:0] s2_byp_data;

  logic            ram_we;
  logic [CH_W-1:0] ram_q;
  logic [CH_W-1:0] rd_data;
  logic [CH_W-1:0] wr_data;

  assign advance   = !res_valid || !res_stall;
  assign cmd_stall = !advance;
  assign step_en   = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= cmd_valid;
    end
    if (advance && cmd_valid) begin
      s1_op  <= op;
      s1_ch  <= ch_in;
      s1_pos <= position;
    end
  end

  gbl_cursor #(
    .DEPTH(DEPTH)
  ) u_cursor (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .op      (s1_op),
    .ch_in   (s1_ch),
    .position(s1_pos),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .step    (step)
  );

  assign rd_data = s2_byp_hit ? s2_byp_data : ram_q;
  assign wr_data = s2_step.wr_from_mem ? rd_data : s2_step.ch;
  assign ram_we  = s2_valid && s2_step.wr_en && advance;

  gbl_ram #(
    .WIDTH(CH_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s2_wr_addr),
    .wdata(wr_data),
    .re   (step_en && rd_en),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid;
    end
    if (step_en) begin
      s2_step     <= step;
      s2_wr_addr  <= wr_addr;
      s2_byp_hit  <= ram_we && (s2_wr_addr == rd_addr);
      s2_byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s2_valid;
    end
    if (advance && s2_valid) begin
      ch_out      <= s2_step.rd_to_out ? rd_data : '0;
      text_length <= s2_step.text_length;
      cursor_pos  <= s2_step.cursor_pos;
      status      <= s2_step.status;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/gbl_checker.sv
// ----------------------------------------------------------------------------
// Gap buffer line editor checker
// Port-level properties of the line editor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gap_buffer_line_editor_defines.svh"

module gbl_checker import gbl_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 res_valid,
  input logic                 res_stall,
  input logic [CH_W-1:0]      ch_out,
  input logic [CNT_OUT_W-1:0] text_length,
  input logic [CNT_OUT_W-1:0] cursor_pos,
  input logic [ST_W-1:0]      status
);

  `GBL_ASSERT_ALWAYS(a_rst_clears_res, clk, rst, !res_valid)
  `GBL_ASSERT_NOW(a_cursor_in_text, clk, rst, res_valid, cursor_pos <= text_length)
  `GBL_ASSERT_NOW(a_range_no_data, clk, rst, res_valid && (status == ST_RANGE), ch_out == '0)
  `GBL_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(ch_out) && $stable(text_length) && $stable(cursor_pos) && $stable(status))

endmodule

bind gap_buffer_line_editor gbl_checker u_gbl_checker (.*);

`default_nettype wire
